// File: src/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants for the closest pair distance core
// Point, result and chain token formats used by the cell row and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SqW    = 32;  // square of a 17-bit difference
  localparam int unsigned DistW  = 33;  // sum of two squares
  localparam int unsigned MinW   = 34;  // running minimum, all ones = no pair
  localparam int unsigned RootW  = 25;

  localparam logic [MinW-1:0] MIN_NONE = {MinW{1'b1}};

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0] min_dist_sq;
    logic [RootW-1:0] min_dist_q8;
    logic             pair_found;
    logic             overflow;
  } res_t;

  // Token walking down the cell row, one cell per cycle. The squares taken in
  // one cell are folded into the minimum in the next.
  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic                     placed;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [MinW-1:0]          min;
    logic                     pend_vld;
    logic [SqW-1:0]           sqx;
    logic [SqW-1:0]           sqy;
  } tok_t;

endpackage

`default_nettype wire

// File: src/cpd_cell.sv
// ----------------------------------------------------------------------------
// cpd_cell: one slot of the point row
// Holds one stored point, squares its distance to a passing token and claims
// the point of an unplaced token that is not the closing beat when the slot is still empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_cell
  import cpd_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  tok_t tok_i,
  output tok_t       tok_o
);

  logic                     occ_q;
  logic signed [CoordW-1:0] sx_q;
  logic signed [CoordW-1:0] sy_q;
  tok_t                     tok_q;
  tok_t                     tok_d;

  logic [DistW-1:0]         sum;
  logic [MinW-1:0]          sum_w;
  logic signed [CoordW:0]   dx;
  logic signed [CoordW:0]   dy;
  logic signed [2*CoordW+1:0] px;
  logic signed [2*CoordW+1:0] py;

  always_comb begin
    sum   = {1'b0, tok_i.sqx} + {1'b0, tok_i.sqy};
    sum_w = {1'b0, sum};
    dx    = {tok_i.x[CoordW-1], tok_i.x} - {sx_q[CoordW-1], sx_q};
    dy    = {tok_i.y[CoordW-1], tok_i.y} - {sy_q[CoordW-1], sy_q};
    px    = dx * dx;
    py    = dy * dy;

    tok_d          = tok_i;
    tok_d.min      = (tok_i.pend_vld && (sum_w < tok_i.min)) ? sum_w : tok_i.min;
    tok_d.pend_vld = tok_i.vld && !tok_i.placed && occ_q;
    tok_d.sqx      = px[SqW-1:0];
    tok_d.sqy      = py[SqW-1:0];
    tok_d.placed   = tok_i.placed || (tok_i.vld && !occ_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      occ_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.vld) begin
        // the closing beat of a set empties every slot behind it
        if (tok_i.last) begin
          occ_q <= 1'b0;
        end else if (!tok_i.placed && !occ_q) begin
          occ_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld && !tok_i.last && !tok_i.placed && !occ_q) begin
      sx_q <= tok_i.x;
      sy_q <= tok_i.y;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// File: src/cpd_isqrt.sv
// ----------------------------------------------------------------------------
// cpd_isqrt: bit-serial integer square root
// Floor root of the squared distance scaled by 2^16, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_isqrt
  import cpd_pkg::*;
(
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             start_i,
  input  wire  logic [DistW-1:0] rad_i,
  output logic                   done_o,
  output logic [RootW-1:0]       root_o
);

  localparam int unsigned RadW = 2 * RootW;   // padded radicand
  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned CntW = $clog2(RootW);
  localparam logic [CntW-1:0] CntLast = CntW'(RootW - 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic             done_q;

  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;
  logic             take;

  always_comb begin
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {root_q, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, rad_i, 16'h0000};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: src/closest_pair_distance_core.sv
// ----------------------------------------------------------------------------
// closest_pair_distance_core: smallest distance within a set of points
// A row of MAX_POINTS cells stores the set; each point walks the row as a token
// and keeps the smallest squared distance it meets.
//
//   port      dir  kind     notes
//   start_i   in   strobe   point beat taken when busy_o is low
//   in_i      in   in_t     point_x, point_y, last_point
//   busy_o    out  level    high from the closing beat until its result
//   done_o    out  strobe   one cycle, result beat
//   result_o  out  res_t    min_dist_sq, min_dist_q8, pair_found, overflow
//
// Within a set one point is taken every cycle. After the beat carrying
// last_point the core stays busy while the token walks the remaining cells,
// the tail folds in the last squares, the root unit is loaded and produces
// the root one bit a cycle, and the result is registered. Reset empties the
// row and clears the running minimum. The receiver cannot stall; the result
// beat is flagged by done_o for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_pair_distance_core
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 128
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic start_i,
  input  wire  in_t  in_i,
  output logic       busy_o,
  output logic       done_o,
  output res_t       result_o
);

  localparam logic [1:0] ST_OPEN  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_ROOT  = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  logic acc;
  tok_t tok_w [MAX_POINTS+1];

  logic             tl_vld_q;
  logic             tl_last_q;
  logic             tl_placed_q;
  logic [MinW-1:0]  tl_min_q;
  logic [DistW-1:0] tl_sum;
  logic [MinW-1:0]  tl_min_d;

  logic [MinW-1:0]  glob_min_q;
  logic             glob_drop_q;
  logic [MinW-1:0]  cand;
  logic             drop;
  logic             pair;
  logic             close_set;

  logic             root_done;
  logic [RootW-1:0] root;
  logic             done_q;
  res_t             res_q;

  assign acc = start_i && !busy_o;

  always_comb begin
    tok_w[0]          = '0;
    tok_w[0].vld      = acc;
    tok_w[0].last     = in_i.last_point;
    tok_w[0].x        = in_i.point_x;
    tok_w[0].y        = in_i.point_y;
    tok_w[0].min      = MIN_NONE;
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    cpd_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok_w[g]),
      .tok_o (tok_w[g+1])
    );
  end

  // fold in the squares from the final cell
  always_comb begin
    tl_sum   = {1'b0, tok_w[MAX_POINTS].sqx} + {1'b0, tok_w[MAX_POINTS].sqy};
    tl_min_d = (tok_w[MAX_POINTS].pend_vld && ({1'b0, tl_sum} < tok_w[MAX_POINTS].min))
               ? {1'b0, tl_sum} : tok_w[MAX_POINTS].min;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_vld_q <= 1'b0;
    end else begin
      tl_vld_q <= tok_w[MAX_POINTS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tl_last_q   <= tok_w[MAX_POINTS].last;
    tl_placed_q <= tok_w[MAX_POINTS].placed;
    tl_min_q    <= tl_min_d;
  end

  // an unplaced token found the row full: its point is dropped and its distances are not folded in
  always_comb begin
    cand = glob_min_q;
    if (tl_vld_q && tl_placed_q && (tl_min_q < glob_min_q)) begin
      cand = tl_min_q;
    end
    drop      = glob_drop_q || (tl_vld_q && !tl_placed_q);
    pair      = cand != MIN_NONE;
    close_set = tl_vld_q && tl_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glob_min_q  <= MIN_NONE;
      glob_drop_q <= 1'b0;
    end else if (close_set) begin
      glob_min_q  <= MIN_NONE;
      glob_drop_q <= 1'b0;
    end else if (tl_vld_q) begin
      glob_min_q  <= cand;
      glob_drop_q <= drop;
    end
  end

  cpd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(close_set),
    .rad_i  (pair ? cand[DistW-1:0] : '0),
    .done_o (root_done),
    .root_o (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_OPEN:  if (acc && in_i.last_point) state_d = ST_FLUSH;
      ST_FLUSH: if (close_set) state_d = ST_ROOT;
      ST_ROOT:  if (root_done) state_d = ST_OPEN;
      default:  state_d = ST_OPEN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_OPEN;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= root_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_set) begin
      res_q.min_dist_sq <= pair ? cand[DistW-1:0] : '0;
      res_q.pair_found  <= pair;
      res_q.overflow    <= drop;
    end
    if (root_done) begin
      res_q.min_dist_q8 <= root;
    end
  end

  assign busy_o   = state_q != ST_OPEN;
  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_after_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_ROOT))
    else $error("result beat without a root pass");

  a_close_in_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_set |-> state_q == ST_FLUSH)
    else $error("closing token reached the tail outside a flush");

  a_last_starts_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.last_point) |=> state_q == ST_FLUSH)
    else $error("closing beat did not start a flush");

  a_no_pair_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.pair_found) |->
      (result_o.min_dist_sq == '0) && (result_o.min_dist_q8 == '0))
    else $error("distance reported without a pair");

endmodule

`default_nettype wire
